// ===== hw/rtl/cawf_pkg.sv =====
// ----------------------------------------------------------------------------
// cawf_pkg
// Types and constants shared by the 8/16-bit ALU with flags.
// ----------------------------------------------------------------------------
`default_nettype none

package cawf_pkg;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_ADC    = 5'd1,
    OP_SUB    = 5'd2,
    OP_SBC    = 5'd3,
    OP_AND    = 5'd4,
    OP_XOR    = 5'd5,
    OP_OR     = 5'd6,
    OP_CP     = 5'd7,
    OP_INC8   = 5'd8,
    OP_DEC8   = 5'd9,
    OP_DAA    = 5'd10,
    OP_CPL    = 5'd11,
    OP_SCF    = 5'd12,
    OP_CCF    = 5'd13,
    OP_INC16  = 5'd14,
    OP_DEC16  = 5'd15,
    OP_ADD16  = 5'd16,
    OP_ADDSPE = 5'd17
  } op_t;

  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;

  typedef struct packed {
    logic [4:0]  op;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        zero_in;
    logic        subtract_in;
    logic        half_in;
    logic        cflag_in;
  } in_t;

  typedef struct packed {
    logic [15:0] result;
    logic        zero_out;
    logic        subtract_out;
    logic        half_out;
    logic        carry_out;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cawf_stage.sv =====
// ----------------------------------------------------------------------------
// cawf_stage
// One pipeline register with valid/stall handshake on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module cawf_stage #(
  parameter type T = logic
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_stall,
  input  wire T     in_data,
  output      logic out_valid,
  input  wire logic out_stall,
  output      T     out_data
);

  logic valid_r;
  logic valid_nxt;
  T     data_r;

  assign in_stall  = valid_r && out_stall;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // hold while stalled or without valid input, load otherwise
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cawf_alu.sv =====
// ----------------------------------------------------------------------------
// cawf_alu
// Combinational ALU: result and Z/N/H/C flags for one operation.
// ----------------------------------------------------------------------------
`default_nettype none

module cawf_alu
  import cawf_pkg::*;
(
  input  wire in_t  op_in,
  output      out_t op_out
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [8:0]  diff9;
  logic [4:0]  diff_lo;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  daa_adj;
  logic        daa_c;
  logic [7:0]  daa_res;
  logic [16:0] add16;
  logic [12:0] add16_lo;
  logic [15:0] spe;
  logic [4:0]  spe_lo;
  logic [8:0]  spe_byte;
  logic [7:0]  r8;

  assign a   = op_in.operand_a[7:0];
  assign b   = op_in.operand_b[7:0];
  assign cin = ((op_in.op == OP_ADC) || (op_in.op == OP_SBC)) ? op_in.cflag_in : 1'b0;

  assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, cin};
  assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
  assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, cin};
  assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
  assign inc8    = a + 8'd1;
  assign dec8    = a - 8'd1;

  always_comb begin
    daa_adj = 8'd0;
    daa_c   = 1'b0;
    if ((!op_in.subtract_in && (a[3:0] > DAA_LO_LIMIT)) || op_in.half_in) begin
      daa_adj = daa_adj | DAA_LO_ADJ;
    end
    if ((!op_in.subtract_in && (a > DAA_HI_LIMIT)) || op_in.cflag_in) begin
      daa_adj = daa_adj | DAA_HI_ADJ;
      daa_c   = 1'b1;
    end
  end

  assign daa_res  = op_in.subtract_in ? (a - daa_adj) : (a + daa_adj);
  assign add16    = {1'b0, op_in.operand_a} + {1'b0, op_in.operand_b};
  assign add16_lo = {1'b0, op_in.operand_a[11:0]} + {1'b0, op_in.operand_b[11:0]};
  assign spe      = op_in.operand_a + {{8{b[7]}}, b};
  assign spe_lo   = {1'b0, op_in.operand_a[3:0]} + {1'b0, b[3:0]};
  assign spe_byte = {1'b0, op_in.operand_a[7:0]} + {1'b0, b};

  always_comb begin
    op_out.result       = op_in.operand_a;
    op_out.zero_out     = op_in.zero_in;
    op_out.subtract_out = op_in.subtract_in;
    op_out.half_out     = op_in.half_in;
    op_out.carry_out    = op_in.cflag_in;
    r8                  = 8'd0;
    unique case (op_in.op)
      OP_ADD, OP_ADC: begin
        r8                  = sum9[7:0];
        op_out.result       = {8'd0, r8};
        op_out.zero_out     = (r8 == 8'd0);
        op_out.subtract_out = 1'b0;
        op_out.half_out     = sum_lo[4];
        op_out.carry_out    = sum9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        r8                  = diff9[7:0];
        op_out.result       = (op_in.op == OP_CP) ? {8'd0, a} : {8'd0, r8};
        op_out.zero_out     = (r8 == 8'd0);
        op_out.subtract_out = 1'b1;
        op_out.half_out     = diff_lo[4];
        op_out.carry_out    = diff9[8];
      end
      OP_AND, OP_XOR, OP_OR: begin
        if (op_in.op == OP_AND) begin
          r8 = a & b;
        end else if (op_in.op == OP_XOR) begin
          r8 = a ^ b;
        end else begin
          r8 = a | b;
        end
        op_out.result       = {8'd0, r8};
        op_out.zero_out     = (r8 == 8'd0);
        op_out.subtract_out = 1'b0;
        op_out.half_out     = (op_in.op == OP_AND);
        op_out.carry_out    = 1'b0;
      end
      OP_INC8: begin
        r8                  = inc8;
        op_out.result       = {8'd0, r8};
        op_out.zero_out     = (r8 == 8'd0);
        op_out.subtract_out = 1'b0;
        op_out.half_out     = (r8[3:0] == 4'h0);
      end
      OP_DEC8: begin
        r8                  = dec8;
        op_out.result       = {8'd0, r8};
        op_out.zero_out     = (r8 == 8'd0);
        op_out.subtract_out = 1'b1;
        op_out.half_out     = (r8[3:0] == 4'hF);
      end
      OP_DAA: begin
        r8               = daa_res;
        op_out.result    = {8'd0, r8};
        op_out.zero_out  = (r8 == 8'd0);
        op_out.half_out  = 1'b0;
        op_out.carry_out = daa_c;
      end
      OP_CPL: begin
        r8                  = ~a;
        op_out.result       = {8'd0, r8};
        op_out.subtract_out = 1'b1;
        op_out.half_out     = 1'b1;
      end
      OP_SCF, OP_CCF: begin
        op_out.result       = {8'd0, a};
        op_out.subtract_out = 1'b0;
        op_out.half_out     = 1'b0;
        op_out.carry_out    = (op_in.op == OP_SCF) ? 1'b1 : ~op_in.cflag_in;
      end
      OP_INC16: begin
        op_out.result = op_in.operand_a + 16'd1;
      end
      OP_DEC16: begin
        op_out.result = op_in.operand_a - 16'd1;
      end
      OP_ADD16: begin
        op_out.result       = add16[15:0];
        op_out.subtract_out = 1'b0;
        op_out.half_out     = add16_lo[12];
        op_out.carry_out    = add16[16];
      end
      OP_ADDSPE: begin
        op_out.result       = spe;
        op_out.zero_out     = 1'b0;
        op_out.subtract_out = 1'b0;
        op_out.half_out     = spe_lo[4];
        op_out.carry_out    = spe_byte[8];
      end
      default: begin
        op_out.result = op_in.operand_a;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cpu_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// 8/16-bit CPU ALU with Z/N/H/C flags, DAA and 16-bit pointer arithmetic.
//
//   channel  ports                         payload
//   input    in_valid, in_stall, in_data   in_t  (op, operands, flags)
//   result   out_valid, out_stall, out_data out_t (result, new flags)
//
// One item per cycle sustained while out_stall stays low; each beat passes
// through the input register, the ALU logic and the result register before
// it shows on out_valid.
// Synchronous active-low reset empties both registers.
// A stalled result holds; the input register still takes a beat while empty.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_alu_with_flags
  import cawf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_stall,
  input  wire in_t  in_data,
  output      logic out_valid,
  input  wire logic out_stall,
  output      out_t out_data
);

  logic mid_valid;
  logic mid_stall;
  in_t  mid_data;
  out_t alu_data;

  cawf_stage #(.T(in_t)) u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (mid_valid),
    .out_stall (mid_stall),
    .out_data  (mid_data)
  );

  cawf_alu u_alu (
    .op_in  (mid_data),
    .op_out (alu_data)
  );

  cawf_stage #(.T(out_t)) u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_stall  (mid_stall),
    .in_data   (alu_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sim/tb_cpu_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// tb_cpu_alu_with_flags
// Checks the 8/16-bit ALU with flags against its own result/flag predictor.
// Every accepted input beat queues a predicted result and flags. Every
// accepted result beat is compared field by field with the oldest one.
// Stimulus is a directed set of corner cases, then random operations with
// random idling on both channels, a calm window and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cpu_alu_with_flags
  import cawf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] OP_UNUSED_LO = 5'd18;
  localparam logic [4:0] OP_UNUSED_HI = 5'd31;
  localparam int RANDOM_OPS   = 1350;
  localparam int CALM_FROM    = 500;
  localparam int CALM_TO      = 800;
  localparam int HOLD_AT      = 1000;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 23;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 2_000_000;

  class alu_flag_tracker;
    out_t inflight[$];
    int unsigned fault_count;

    function out_t eval(in_t item);
      out_t r;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] t8;
      logic [7:0] adj;
      logic [8:0] s9;
      logic [16:0] s17;
      logic cin;
      logic newc;
      a = item.operand_a[7:0];
      b = item.operand_b[7:0];
      r.result = item.operand_a;
      r.zero_out = item.zero_in;
      r.subtract_out = item.subtract_in;
      r.half_out = item.half_in;
      r.carry_out = item.cflag_in;
      case (item.op)
        OP_ADD, OP_ADC: begin
          cin = (item.op == OP_ADC) && item.cflag_in;
          s9 = {1'b0, a} + {1'b0, b} + {8'h00, cin};
          r.half_out = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin}) > 5'h0F;
          r.carry_out = s9[8];
          r.result = {8'h00, s9[7:0]};
          r.zero_out = (s9[7:0] == 8'h00);
          r.subtract_out = 1'b0;
        end
        OP_SUB, OP_SBC, OP_CP: begin
          cin = (item.op == OP_SBC) && item.cflag_in;
          r.half_out = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, cin});
          r.carry_out = {1'b0, a} < ({1'b0, b} + {8'h00, cin});
          t8 = a - b - {7'h00, cin};
          r.zero_out = (t8 == 8'h00);
          r.subtract_out = 1'b1;
          r.result = {8'h00, (item.op == OP_CP) ? a : t8};
        end
        OP_AND, OP_XOR, OP_OR: begin
          if (item.op == OP_AND) t8 = a & b;
          else if (item.op == OP_XOR) t8 = a ^ b;
          else t8 = a | b;
          r.result = {8'h00, t8};
          r.zero_out = (t8 == 8'h00);
          r.subtract_out = 1'b0;
          r.half_out = (item.op == OP_AND);
          r.carry_out = 1'b0;
        end
        OP_INC8: begin
          t8 = a + 8'h01;
          r.result = {8'h00, t8};
          r.zero_out = (t8 == 8'h00);
          r.subtract_out = 1'b0;
          r.half_out = (t8[3:0] == 4'h0);
        end
        OP_DEC8: begin
          t8 = a - 8'h01;
          r.result = {8'h00, t8};
          r.zero_out = (t8 == 8'h00);
          r.subtract_out = 1'b1;
          r.half_out = (t8[3:0] == 4'hF);
        end
        OP_DAA: begin
          adj = 8'h00;
          newc = 1'b0;
          if ((!item.subtract_in && a[3:0] > DAA_LO_LIMIT) || item.half_in)
            adj = adj | DAA_LO_ADJ;
          if ((!item.subtract_in && a > DAA_HI_LIMIT) || item.cflag_in) begin
            adj = adj | DAA_HI_ADJ;
            newc = 1'b1;
          end
          t8 = item.subtract_in ? (a - adj) : (a + adj);
          r.result = {8'h00, t8};
          r.zero_out = (t8 == 8'h00);
          r.half_out = 1'b0;
          r.carry_out = newc;
        end
        OP_CPL: begin
          r.result = {8'h00, ~a};
          r.subtract_out = 1'b1;
          r.half_out = 1'b1;
        end
        OP_SCF, OP_CCF: begin
          r.result = {8'h00, a};
          r.subtract_out = 1'b0;
          r.half_out = 1'b0;
          r.carry_out = (item.op == OP_SCF) ? 1'b1 : !item.cflag_in;
        end
        OP_INC16: r.result = item.operand_a + 16'h0001;
        OP_DEC16: r.result = item.operand_a - 16'h0001;
        OP_ADD16: begin
          s17 = {1'b0, item.operand_a} + {1'b0, item.operand_b};
          r.half_out = ({1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]})
                       > 13'h0FFF;
          r.carry_out = s17[16];
          r.result = s17[15:0];
          r.subtract_out = 1'b0;
        end
        OP_ADDSPE: begin
          r.half_out = ({1'b0, item.operand_a[3:0]} + {1'b0, b[3:0]}) > 5'h0F;
          r.carry_out = ({1'b0, item.operand_a[7:0]} + {1'b0, b}) > 9'h0FF;
          r.result = item.operand_a + {{8{b[7]}}, b};
          r.zero_out = 1'b0;
          r.subtract_out = 1'b0;
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_issue(in_t item);
      inflight.push_back(eval(item));
    endfunction

    function void flag_fault(string what, logic [15:0] want, logic [15:0] got);
      if (fault_count < 10)
        $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
      fault_count++;
    endfunction

    function void check_retire(out_t got);
      out_t want;
      if (inflight.size() == 0) begin
        flag_fault("unexpected result", 16'h0000, got.result);
        return;
      end
      want = inflight.pop_front();
      if (got.result !== want.result)
        flag_fault("result", want.result, got.result);
      if (got.zero_out !== want.zero_out)
        flag_fault("zero_out", {15'h0, want.zero_out}, {15'h0, got.zero_out});
      if (got.subtract_out !== want.subtract_out)
        flag_fault("subtract_out", {15'h0, want.subtract_out}, {15'h0, got.subtract_out});
      if (got.half_out !== want.half_out)
        flag_fault("half_out", {15'h0, want.half_out}, {15'h0, got.half_out});
      if (got.carry_out !== want.carry_out)
        flag_fault("carry_out", {15'h0, want.carry_out}, {15'h0, got.carry_out});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  bit steady = 1'b0;
  bit held_off = 1'b0;
  int issued_count = 0;

  alu_flag_tracker tracker = new();

  cpu_alu_with_flags u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_issue(in_data);
      if (out_valid && !out_stall) tracker.check_retire(out_data);
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      if (!held_off && issued_count >= HOLD_AT) begin
        held_off = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  task automatic send_op(input in_t item);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    issued_count++;
  endtask

  task automatic send_fields(input logic [4:0] op, input logic [15:0] a,
                             input logic [15:0] b, input logic [3:0] znhc);
    send_op({op, a, b, znhc});
  endtask

  function automatic in_t roll_alu_op();
    in_t item;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    item = raw[$bits(in_t)-1:0];
    if ($urandom_range(9) == 0)
      item.op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    else
      item.op = 5'($urandom_range(OP_ADD, OP_ADDSPE));
    return item;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_fields(OP_ADD,    16'h00FF, 16'h0001, 4'b0000);
    send_fields(OP_ADC,    16'hAB0F, 16'hCD00, 4'b0001);
    send_fields(OP_SUB,    16'h0000, 16'h0001, 4'b1000);
    send_fields(OP_SBC,    16'h0010, 16'hFF0F, 4'b0001);
    send_fields(OP_AND,    16'hFFAA, 16'hFF55, 4'b0000);
    send_fields(OP_XOR,    16'h12FF, 16'h34FF, 4'b1111);
    send_fields(OP_OR,     16'hFF00, 16'hFF00, 4'b0000);
    send_fields(OP_CP,     16'h553C, 16'h003C, 4'b0000);
    send_fields(OP_INC8,   16'hFFFF, 16'h0000, 4'b0101);
    send_fields(OP_DEC8,   16'h0000, 16'h0000, 4'b0001);
    send_fields(OP_DEC8,   16'h0010, 16'h0000, 4'b0000);
    send_fields(OP_DAA,    16'h009A, 16'h0000, 4'b0000);
    send_fields(OP_DAA,    16'h0000, 16'h0000, 4'b0000);
    send_fields(OP_DAA,    16'h0000, 16'h0000, 4'b0111);
    send_fields(OP_DAA,    16'h00FF, 16'h0000, 4'b0100);
    send_fields(OP_CPL,    16'hFF5A, 16'h0000, 4'b1001);
    send_fields(OP_SCF,    16'hFF77, 16'h0000, 4'b0110);
    send_fields(OP_CCF,    16'hFF77, 16'h0000, 4'b1111);
    send_fields(OP_INC16,  16'hFFFF, 16'h0000, 4'b1111);
    send_fields(OP_DEC16,  16'h0000, 16'h0000, 4'b0000);
    send_fields(OP_ADD16,  16'h0FFF, 16'h0001, 4'b1000);
    send_fields(OP_ADD16,  16'hFFFF, 16'hFFFF, 4'b0110);
    send_fields(OP_ADDSPE, 16'hFFF8, 16'hFF08, 4'b1100);
    send_fields(OP_ADDSPE, 16'h0000, 16'h0080, 4'b1111);
    send_fields(OP_UNUSED_LO, 16'hBEEF, 16'hFFFF, 4'b1111);
    send_fields(OP_UNUSED_HI, 16'h1234, 16'h0000, 4'b0000);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      steady = (i >= CALM_FROM) && (i < CALM_TO);
      send_op(roll_alu_op());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (tracker.inflight.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.fault_count == 0 && tracker.inflight.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
